@@ hw/rtl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Page frame allocator package
// Shared types, sizes and codes for the bitmap first-fit page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int FRAME_COUNT  = 1024;
  localparam int REGION_BASE  = 0;
  localparam int FRAME_SHIFT  = 12;
  localparam int ADDR_W       = 32;
  localparam int WORD_W       = 32;
  localparam int BIT_W        = $clog2(WORD_W);
  localparam int ROW_COUNT    = (FRAME_COUNT + WORD_W - 1) / WORD_W;
  localparam int ROW_W        = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CMP_W        = ROW_W + BIT_W + 1;
  localparam int LAST_BITS    = FRAME_COUNT - (ROW_COUNT - 1) * WORD_W;
  localparam int REGION_LIMIT = REGION_BASE + FRAME_COUNT * (2 ** FRAME_SHIFT);

  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROW_COUNT - 1);
  localparam logic [WORD_W-1:0] PAD_MASK = {WORD_W{1'b1}} << LAST_BITS;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic [PADDR_W-1:0] REG_RESERVED_END = PADDR_W'(0);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ALIGN   = 2'd3
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    status_t           status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SWEEP,
    S_MODIFY,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic check;
    logic ram_rd;
    logic modify;
    logic sweep;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic err;
    logic sweep_last;
  } dp_stat_t;

endpackage

@@ hw/rtl/pfa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/pfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Page frame allocator controller
// Sequences one request at a time and owns the response valid flag.
// ----------------------------------------------------------------------------
module pfa_ctrl import pfa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic        rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_ready      = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        unique case (stat.op) inside
          OP_INIT: begin
            state_next = S_SWEEP;
          end
          OP_ALLOC, OP_FREE: begin
            if (stat.err) begin
              state_next = S_FINISH;
            end else begin
              cmd.ram_rd = 1'b1;
              state_next = S_MODIFY;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_FINISH;
        end
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/pfa_dp.sv @@
// ----------------------------------------------------------------------------
// Page frame allocator datapath
// Holds the frame map in RAM rows with per-row valid and full flags, finds
// the first free frame and builds the response.
// ----------------------------------------------------------------------------
module pfa_dp import pfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  req_t              req,
  input  logic [ADDR_W-1:0] reserved_end_address,
  output dp_stat_t          stat,
  output rsp_t              rsp
);

  op_t               op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CMP_W-1:0]  ff_q;
  logic [ROW_W-1:0]  sweep_cnt;
  logic [ROW_W-1:0]  row_q;
  logic              vld_q;
  logic [ROW_COUNT-1:0] row_valid;
  logic [ROW_COUNT-1:0] row_full;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;

  logic [ADDR_W:0]   round_sum;
  logic [ADDR_W-FRAME_SHIFT:0] ff_raw;
  logic [CMP_W-1:0]  ff_clamped;
  logic              any_free;
  logic [ROW_W-1:0]  sel_row;
  logic              range_err;
  logic              align_err;
  status_t           chk_status;
  logic              chk_err;
  logic [ROW_W-1:0]  free_row;
  logic [BIT_W-1:0]  free_bit;
  logic [ROW_W-1:0]  rd_row;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] cur_word;
  logic [BIT_W-1:0]  zero_bit;
  logic [WORD_W-1:0] mod_word;
  logic [CMP_W-1:0]  row_start;
  logic [CMP_W-1:0]  row_used;
  logic [WORD_W-1:0] sweep_word;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_row;
  logic [WORD_W-1:0] wr_word;
  logic [ADDR_W-1:0] alloc_addr;

  assign round_sum  = {1'b0, reserved_end_address} + (ADDR_W+1)'((2 ** FRAME_SHIFT) - 1);
  assign ff_raw     = round_sum[ADDR_W:FRAME_SHIFT];
  assign ff_clamped = (ff_raw > (ADDR_W-FRAME_SHIFT+1)'(FRAME_COUNT))
                      ? CMP_W'(FRAME_COUNT) : CMP_W'(ff_raw);

  always_comb begin
    any_free = 1'b0;
    sel_row  = '0;
    for (int i = ROW_COUNT - 1; i >= 0; i--) begin
      if (!row_full[i]) begin
        any_free = 1'b1;
        sel_row  = ROW_W'(i);
      end
    end
  end

  assign range_err = (addr_q < ADDR_W'(REGION_BASE)) || (addr_q >= ADDR_W'(REGION_LIMIT));
  assign align_err = |addr_q[FRAME_SHIFT-1:0];
  assign free_bit  = addr_q[FRAME_SHIFT +: BIT_W];
  assign free_row  = ROW_W'((addr_q - ADDR_W'(REGION_BASE)) >> (FRAME_SHIFT + BIT_W));

  always_comb begin
    chk_status = ST_DONE;
    case (op_q)
      OP_ALLOC: begin
        if (!any_free) begin
          chk_status = ST_NO_FREE;
        end
      end
      OP_FREE: begin
        if (range_err) begin
          chk_status = ST_RANGE;
        end else if (align_err) begin
          chk_status = ST_ALIGN;
        end
      end
      default: begin
        chk_status = ST_DONE;
      end
    endcase
  end

  assign chk_err = (chk_status != ST_DONE);
  assign rd_row  = (op_q == OP_ALLOC) ? sel_row : free_row;

  pfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROW_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_row),
    .wdata (wr_word),
    .re    (cmd.ram_rd),
    .raddr (rd_row),
    .rdata (ram_rdata)
  );

  assign cur_word = vld_q ? ram_rdata : ((row_q == LAST_ROW) ? PAD_MASK : '0);

  always_comb begin
    zero_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!cur_word[b]) begin
        zero_bit = BIT_W'(b);
      end
    end
  end

  assign mod_word = (op_q == OP_ALLOC)
                    ? (cur_word | (WORD_W'(1) << zero_bit))
                    : (cur_word & ~(WORD_W'(1) << free_bit));

  assign alloc_addr = ADDR_W'(REGION_BASE) + ADDR_W'({row_q, zero_bit, FRAME_SHIFT'(0)});

  assign row_start = CMP_W'({sweep_cnt, BIT_W'(0)});
  assign row_used  = ff_q - row_start;

  always_comb begin
    if (ff_q <= row_start) begin
      sweep_word = '0;
    end else if (row_used >= CMP_W'(WORD_W)) begin
      sweep_word = '1;
    end else begin
      sweep_word = ~({WORD_W{1'b1}} << row_used[BIT_W-1:0]);
    end
    if (sweep_cnt == LAST_ROW) begin
      sweep_word = sweep_word | PAD_MASK;
    end
  end

  assign wr_en   = cmd.modify || cmd.sweep;
  assign wr_row  = cmd.sweep ? sweep_cnt : row_q;
  assign wr_word = cmd.sweep ? sweep_word : mod_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_full  <= '0;
    end else if (wr_en) begin
      row_valid[wr_row] <= 1'b1;
      row_full[wr_row]  <= &wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q       <= req.operation;
      addr_q     <= req.free_addr;
      ff_q       <= ff_clamped;
      sweep_cnt  <= '0;
      res_status <= ST_DONE;
      res_addr   <= '0;
    end
    if (cmd.check) begin
      res_status <= chk_status;
    end
    if (cmd.ram_rd) begin
      row_q <= rd_row;
      vld_q <= row_valid[rd_row];
    end
    if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + ROW_W'(1);
    end
    if (cmd.modify && (op_q == OP_ALLOC)) begin
      res_addr <= alloc_addr;
    end
    if (cmd.load_out) begin
      rsp.frame_address <= res_addr;
      rsp.status        <= res_status;
    end
  end

  assign stat.op         = op_q;
  assign stat.err        = chk_err;
  assign stat.sweep_last = (sweep_cnt == LAST_ROW);

endmodule

@@ hw/rtl/bitmap_page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap page frame allocator
// First-fit allocator over a used-bit map of 4 KiB frames, with init, alloc
// and free requests and an APB register for the reserved region end.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_t: operation, free_addr
// rsp       rsp_valid/rsp_ready    rsp_t: frame_address, status
// apb       psel/penable/pready    paddr, pwdata, prdata
//
// Alloc and free go through the check, modify and finish states; errors and the
// unused operation skip modify. Init sweeps the map RAM one row per cycle.
// The row-full flags pick the first row with a free frame, so alloc needs a
// single RAM read. Reset empties the map at once through per-row valid flags.
// A stalled response holds in its register while the next request is taken.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator import pfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [ADDR_W-1:0] reserved_end_address;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_end_address <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_RESERVED_END)) begin
      reserved_end_address <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr)
      REG_RESERVED_END: prdata = reserved_end_address;
      default:          prdata = '0;
    endcase
  end

  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfa_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .req                  (req),
    .reserved_end_address (reserved_end_address),
    .stat                 (stat),
    .rsp                  (rsp)
  );

endmodule

@@ hw/rtl/pfa_checker.sv @@
// ----------------------------------------------------------------------------
// Page frame allocator checker
// Port-level assertions, bound to the allocator top level.
// ----------------------------------------------------------------------------
module pfa_checker import pfa_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input rsp_t               rsp,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  a_error_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_DONE) |-> (rsp.frame_address == '0))
    else $error("failed request returned a frame address");

  a_addr_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.frame_address[FRAME_SHIFT-1:0] == '0))
    else $error("frame address not on a frame boundary");

  a_reg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr == REG_RESERVED_END)
    |=> !(psel && (paddr == REG_RESERVED_END)) || (prdata == $past(pwdata)))
    else $error("register read does not return the last write");

endmodule

bind bitmap_page_frame_allocator pfa_checker u_pfa_checker (.*);
